>>> rtl/core/hct_pkg.sv
// Shared constants, codes and queue entry type for the completion tracker.
package hct_pkg;

  localparam int MAX_OWNERS = 16;
  localparam int MAX_PAGES  = 16;
  localparam int COUNT_BITS = 16;

  localparam int SLOTS      = MAX_OWNERS * MAX_PAGES;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int OWN_CNT_W  = $clog2(MAX_OWNERS + 1);
  localparam int PAGE_CNT_W = $clog2(MAX_PAGES + 1);

  // Field widths of the streams
  localparam int MODE_W   = 2;
  localparam int OWNER_W  = 4;
  localparam int PAGE_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Largest job count that fits the counters, one bit wider than the amount field
  localparam logic [AMOUNT_W:0] COUNT_MAX = (AMOUNT_W + 1)'((64'd1 << COUNT_BITS) - 64'd1);

  // Queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Item modes
  localparam logic [MODE_W-1:0] MODE_PAGES  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JOBS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_PREP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 2'd3;

  // One classified item waiting for the back end
  typedef struct packed {
    logic                range_err;
    logic [MODE_W-1:0]   mode;
    logic [OWNER_W-1:0]  owner;
    logic [PAGE_W-1:0]   page;
    logic [AMOUNT_W-1:0] amount;
  } hct_entry_t;

endpackage

>>> rtl/core/hct_front.sv
// Front end: accepts input beats, holds the owner count and flags static range errors.
module hct_front
  import hct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [MODE_W-1:0]     in_tuser,   // mode
  input  logic [IN_DATA_W-1:0]  in_tdata,   // owner, page, amount
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  q_full,
  output logic                  q_push,
  output hct_entry_t            q_entry,
  output logic [OWN_CNT_W-1:0]  num_owners
);

  logic [OWN_CNT_W-1:0] num_owners_r;
  logic [OWN_CNT_W-1:0] num_owners_nxt;
  logic [OWNER_W-1:0]   owner;
  logic [AMOUNT_W-1:0]  amount;

  // Clamp the written owner count into 1..MAX_OWNERS
  always_comb begin
    if (cfg_wdata == '0) begin
      num_owners_nxt = OWN_CNT_W'(1);
    end else if ({1'b0, cfg_wdata} > (CFG_W + 1)'(MAX_OWNERS)) begin
      num_owners_nxt = OWN_CNT_W'(MAX_OWNERS);
    end else begin
      num_owners_nxt = OWN_CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_owners_r <= OWN_CNT_W'(1);
    end else if (cfg_wen) begin
      num_owners_r <= num_owners_nxt;
    end
  end

  assign num_owners = num_owners_r;
  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && !q_full;

  assign owner  = in_tdata[OWNER_W-1:0];
  assign amount = in_tdata[OWNER_W+PAGE_W +: AMOUNT_W];

  // Classify: checks that need no table state
  always_comb begin
    q_entry.mode   = in_tuser;
    q_entry.owner  = owner;
    q_entry.page   = in_tdata[OWNER_W +: PAGE_W];
    q_entry.amount = amount;
    q_entry.range_err = (in_tuser == MODE_UNUSED) ||
                        ((OWN_CNT_W + 1)'(owner) >= (OWN_CNT_W + 1)'(num_owners_r)) ||
                        ((in_tuser == MODE_PAGES) &&
                         ((amount == '0) || (amount > AMOUNT_W'(MAX_PAGES))));
  end

endmodule

>>> rtl/core/hct_queue.sv
// Short FIFO of classified items between front and back.
module hct_queue
  import hct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clear,
  input  logic       push,
  input  hct_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output hct_entry_t head_entry
);

  hct_entry_t        slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_pop;

  assign full       = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QPTR_W + 1)'(push && !full) - (QPTR_W + 1)'(do_pop);
    end
  end

endmodule

>>> rtl/core/hct_back.sv
// Back end: read-modify-write of the page and owner tables and the result register.
module hct_back
  import hct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_clear,
  input  logic [OWN_CNT_W-1:0]  num_owners,
  input  logic                  q_valid,
  input  hct_entry_t            q_entry,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_r;
  hct_entry_t            ent_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [SLOT_W-1:0]     slot;
  logic [2*COUNT_BITS-1:0] job_mem [SLOTS];
  logic [2*COUNT_BITS-1:0] rd_data_r;

  logic [SLOTS-1:0]      jobs_set_r;
  logic [PAGE_CNT_W-1:0] owner_pages_r      [MAX_OWNERS];
  logic [PAGE_CNT_W-1:0] owner_pages_done_r [MAX_OWNERS];
  logic [OWN_CNT_W-1:0]  owners_done_r;
  logic [OWN_CNT_W-1:0]  owners_done_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  exec_fire;
  logic [STATUS_W-1:0]   status;
  logic                  page_done;
  logic                  owner_done;
  logic                  all_done;
  logic                  mem_we;
  logic [2*COUNT_BITS-1:0] mem_wdata;
  logic                  set_pages;
  logic                  set_jobs;
  logic                  pdone_we;
  logic [PAGE_CNT_W-1:0] pdone_nxt;

  logic [PAGE_CNT_W-1:0] cur_pages;
  logic [PAGE_CNT_W-1:0] cur_pdone;
  logic [PAGE_CNT_W-1:0] pdone_inc;
  logic [COUNT_BITS-1:0] exp_cnt;
  logic [COUNT_BITS-1:0] fin_cnt;
  logic [COUNT_BITS-1:0] fin_inc;
  logic                  page_fin;

  assign slot = SLOT_W'(q_entry.owner) * SLOT_W'(MAX_PAGES) + SLOT_W'(q_entry.page);
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // Sequence: fetch the entry and its job counters, then execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_fire) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Latch the popped entry
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r  <= q_entry;
      slot_r <= slot;
    end
  end

  // Job counter memory: expected count high, finished count low
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data_r <= job_mem[slot];
    end
    if (exec_fire && mem_we) begin
      job_mem[slot_r] <= mem_wdata;
    end
  end

  assign cur_pages = owner_pages_r[ent_r.owner];
  assign cur_pdone = owner_pages_done_r[ent_r.owner];
  assign exp_cnt   = rd_data_r[2*COUNT_BITS-1:COUNT_BITS];
  assign fin_cnt   = rd_data_r[COUNT_BITS-1:0];
  assign fin_inc   = fin_cnt + 1'b1;
  assign pdone_inc = (cur_pdone < cur_pages) ? cur_pdone + 1'b1 : cur_pdone;

  // Decide the outcome of the current entry
  always_comb begin
    status          = ST_OK;
    page_fin        = 1'b0;
    mem_we          = 1'b0;
    mem_wdata       = '0;
    set_pages       = 1'b0;
    set_jobs        = 1'b0;
    if (ent_r.range_err) begin
      status = ST_RANGE;
    end else begin
      case (ent_r.mode)
        MODE_PAGES: begin
          if (cur_pages != '0) status = ST_ALREADY;
          else set_pages = 1'b1;
        end
        MODE_JOBS, MODE_FINISH: begin
          if (cur_pages == '0) begin
            status = ST_NOT_PREP;
          end else if ((PAGE_CNT_W + 1)'(ent_r.page) >= (PAGE_CNT_W + 1)'(cur_pages)) begin
            status = ST_RANGE;
          end else if (ent_r.mode == MODE_JOBS) begin
            if (jobs_set_r[slot_r]) begin
              status = ST_ALREADY;
            end else if ({1'b0, ent_r.amount} > COUNT_MAX) begin
              status = ST_ALREADY;
            end else begin
              set_jobs  = 1'b1;
              mem_we    = 1'b1;
              mem_wdata = {COUNT_BITS'(ent_r.amount), {COUNT_BITS{1'b0}}};
              page_fin  = (ent_r.amount == '0);
            end
          end else begin
            if (!jobs_set_r[slot_r]) begin
              status = ST_NOT_PREP;
            end else if (fin_cnt == exp_cnt) begin
              status = ST_ALREADY;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {exp_cnt, fin_inc};
              page_fin  = (fin_inc == exp_cnt);
            end
          end
        end
        default: status = ST_RANGE;
      endcase
    end
  end

  // Roll a completed page up to its owner and to the whole run
  always_comb begin
    page_done       = page_fin;
    pdone_we        = page_fin || set_pages;
    pdone_nxt       = set_pages ? '0 : pdone_inc;
    owner_done      = page_fin && (pdone_inc == cur_pages);
    owners_done_nxt = owners_done_r;
    all_done        = 1'b0;
    if (owner_done) begin
      if (owners_done_r < num_owners) owners_done_nxt = owners_done_r + 1'b1;
      all_done = (owners_done_nxt == num_owners);
    end
  end

  // Update the owner tables and page valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      jobs_set_r    <= '0;
      owners_done_r <= '0;
      for (int i = 0; i < MAX_OWNERS; i++) begin
        owner_pages_r[i]      <= '0;
        owner_pages_done_r[i] <= '0;
      end
    end else if (exec_fire) begin
      if (set_jobs) jobs_set_r[slot_r] <= 1'b1;
      if (set_pages) owner_pages_r[ent_r.owner] <= PAGE_CNT_W'(ent_r.amount);
      if (pdone_we) owner_pages_done_r[ent_r.owner] <= pdone_nxt;
      owners_done_r <= owners_done_nxt;
    end
  end

  // Result register: holds until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= OUT_DATA_W'({all_done, owner_done, page_done, status});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A rejected item reports no completion
  assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && (status != ST_OK) |-> !page_done && !owner_done && !all_done)
    else $error("completion flags set on a rejected item");

  // Completion flags nest: run implies owner implies page
  assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |-> (!all_done || owner_done) && (!owner_done || page_done))
    else $error("completion flags out of order");

  // Completed owner count never passes the tracked owner count
  assert property (@(posedge clk) disable iff (!rst_n)
    owners_done_r <= num_owners)
    else $error("owners done exceeds owner count");

  // An execute step waits while the result register is still full
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && out_valid_r && !out_tready |=> (state_r == S_EXEC))
    else $error("execute step left with result register blocked");

endmodule

>>> rtl/core/hierarchical_completion_tracker_unit.sv
// Top level of the two-level completion tracker: front, queue and back.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready | tuser: mode; tdata: owner, page, amount
//  out_    | out | out_tvalid/out_tready | tdata: status, page_done, owner_done, all_done
//  cfg_    | in  | cfg_wen               | cfg_wdata: num_owners
//
//  Each item passes the back end in a fetch step, which reads its job counters from the
//  single-port counter memory, and an execute step, which updates tables and loads the
//  result register; a new item leaves the queue only after the last one has executed.
//  Reset and a num_owners write clear all tables at once through per-page valid bits
//  and register-based owner counters; there is no clearing pass. A stalled output holds
//  the back end, and the two-entry queue then fills before in_tready drops.
module hierarchical_completion_tracker_unit
  import hct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [MODE_W-1:0]     in_tuser,    // [1:0] mode
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [3:0] owner, [7:4] page, [23:8] amount
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [1:0] status, [2] page_done,
                                             // [3] owner_done, [4] all_done, [7:5] zero
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic                 q_full;
  logic                 q_push;
  hct_entry_t           push_entry;
  logic                 q_pop;
  logic                 q_valid;
  hct_entry_t           head_entry;
  logic [OWN_CNT_W-1:0] num_owners;

  hct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry),
    .num_owners (num_owners)
  );

  hct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_wen),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  hct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_wen),
    .num_owners (num_owners),
    .q_valid    (q_valid),
    .q_entry    (head_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
